/* hdl/csc_pkg.sv */
`timescale 1ns / 1ps
package csc_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W         = 32;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int DIV_STAGES      = DIFF_W;
    localparam int MAX_CLIP_PASSES = 4;

    // region code bits
    localparam logic [3:0] RC_LEFT  = 4'b0001;
    localparam logic [3:0] RC_RIGHT = 4'b0010;
    localparam logic [3:0] RC_BELOW = 4'b0100;
    localparam logic [3:0] RC_ABOVE = 4'b1000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_LOW_Y  = 2'd2,
        REG_HIGH_Y = 2'd3
    } cfg_reg_t;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [3:0]         rcode_t;

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t low_y;
        coord_t high_y;
    } win_t;

    // segment as it travels down the pipeline
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        rcode_t c0;
        rcode_t c1;
        logic   ok;
        logic   rej;
    } seg_t;

    // intersection work in flight through the divider
    typedef struct packed {
        seg_t              seg;
        logic              move;
        logic              mv1;
        logic              y_edge;
        coord_t            a0;
        coord_t            edge_val;
        logic              neg;
        logic [DIFF_W-1:0] md;
        logic [DIFF_W-1:0] rem;
        logic [DIFF_W-1:0] sh;
    } work_t;

endpackage

/* hdl/line_segment_rect_clipper_unit.sv */
`timescale 1ns / 1ps
// Line segment clipper against an axis-aligned window (Cohen-Sutherland).
// Window edges are written through cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce: 0 left, 1 right, 2 low y, 3 high y, all signed Q16.16.
// Input stream s_*: tdata carries start_x, start_y, end_x, end_y (32 bits each).
// Output stream m_*: tuser is the accepted flag, tdata carries the clipped
// start_x, start_y, end_x, end_y; rejected segments return zero coordinates.
// The pipeline is one region stage, then four clip passes of 37 stages
// each (setup, multiply, 33 single-bit divider stages, update, region), then
// the output register. A transaction can enter every cycle while the receiver does not stall, so
// throughput is one segment per cycle; the serial divider sets the depth.
// Reset clears all valid bits and sets the window registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
module line_segment_rect_clipper_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic [0:0]   m_tuser    // accepted
);
    import csc_pkg::*;

    win_t   win_reg;
    logic   en;
    seg_t   in_seg;
    logic   out_valid_reg;
    logic   accepted_reg;
    coord_t sx_reg;
    coord_t sy_reg;
    coord_t ex_reg;
    coord_t ey_reg;
    logic   fin_ok;

    logic   r_valid [0:MAX_CLIP_PASSES];
    seg_t   r_seg   [0:MAX_CLIP_PASSES];
    logic   p_valid [0:MAX_CLIP_PASSES-1];
    seg_t   p_seg   [0:MAX_CLIP_PASSES-1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT:   win_reg.left   <= cfg_data;
                REG_RIGHT:  win_reg.right  <= cfg_data;
                REG_LOW_Y:  win_reg.low_y  <= cfg_data;
                REG_HIGH_Y: win_reg.high_y <= cfg_data;
                default:    win_reg        <= win_reg;
            endcase
        end
    end

    // global advance: hold everything while a result waits
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // unpack input, an empty or zero-width window rejects at once
    always_comb
    begin
        in_seg     = '0;
        in_seg.x0  = s_tdata[31:0];
        in_seg.y0  = s_tdata[63:32];
        in_seg.x1  = s_tdata[95:64];
        in_seg.y1  = s_tdata[127:96];
        in_seg.rej = ($signed(win_reg.right) <= $signed(win_reg.left))
                     || ($signed(win_reg.high_y) <= $signed(win_reg.low_y));
    end

    csc_region_stage u_region0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_seg    (in_seg),
        .win       (win_reg),
        .out_valid (r_valid[0]),
        .out_seg   (r_seg[0])
    );

    // clip passes
    for (genvar k = 0; k < MAX_CLIP_PASSES; k++)
    begin : g_pass
        csc_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (r_valid[k]),
            .in_seg    (r_seg[k]),
            .win       (win_reg),
            .out_valid (p_valid[k]),
            .out_seg   (p_seg[k])
        );

        csc_region_stage u_region (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (p_valid[k]),
            .in_seg    (p_seg[k]),
            .win       (win_reg),
            .out_valid (r_valid[k+1]),
            .out_seg   (r_seg[k+1])
        );
    end

    // final decision after the last pass
    assign fin_ok = r_seg[MAX_CLIP_PASSES].ok
                    || (!r_seg[MAX_CLIP_PASSES].rej
                        && ((r_seg[MAX_CLIP_PASSES].c0 | r_seg[MAX_CLIP_PASSES].c1) == 4'b0000));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r_valid[MAX_CLIP_PASSES];
    end

    // output register, zero coordinates on reject
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            accepted_reg <= fin_ok;
            sx_reg       <= fin_ok ? r_seg[MAX_CLIP_PASSES].x0 : '0;
            sy_reg       <= fin_ok ? r_seg[MAX_CLIP_PASSES].y0 : '0;
            ex_reg       <= fin_ok ? r_seg[MAX_CLIP_PASSES].x1 : '0;
            ey_reg       <= fin_ok ? r_seg[MAX_CLIP_PASSES].y1 : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ey_reg, ex_reg, sy_reg, sx_reg};
    assign m_tuser  = accepted_reg;

    // rejected results carry no coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("rejected segment with nonzero coordinates");

    // a result appears only from a valid final stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(r_valid[MAX_CLIP_PASSES]))
        else $error("result appeared without a finished segment");

    // a stall freezes the last pipeline stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(r_valid[MAX_CLIP_PASSES]) && $stable(r_seg[MAX_CLIP_PASSES])))
        else $error("pipeline moved during a stall");

endmodule

/* hdl/csc_region_stage.sv */
`timescale 1ns / 1ps
module csc_region_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  csc_pkg::seg_t in_seg,
    input  csc_pkg::win_t win,
    output logic          out_valid,
    output csc_pkg::seg_t out_seg
);
    import csc_pkg::*;

    logic valid_reg;
    seg_t seg_reg;
    seg_t seg_next;

    function automatic rcode_t region(input coord_t x, input coord_t y, input win_t w);
        rcode_t c;
        c = '0;
        if ($signed(x) < $signed(w.left))
            c = c | RC_LEFT;
        else if ($signed(x) > $signed(w.right))
            c = c | RC_RIGHT;
        if ($signed(y) < $signed(w.low_y))
            c = c | RC_BELOW;
        else if ($signed(y) > $signed(w.high_y))
            c = c | RC_ABOVE;
        return c;
    endfunction

    // region codes of both endpoints
    always_comb
    begin
        seg_next    = in_seg;
        seg_next.c0 = region(in_seg.x0, in_seg.y0, win);
        seg_next.c1 = region(in_seg.x1, in_seg.y1, win);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            seg_reg <= seg_next;
    end

    assign out_valid = valid_reg;
    assign out_seg   = seg_reg;

endmodule

/* hdl/csc_div_stage.sv */
`timescale 1ns / 1ps
module csc_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  csc_pkg::work_t in_work,
    output logic           out_valid,
    output csc_pkg::work_t out_work
);
    import csc_pkg::*;

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;

    // one restoring division step, quotient bit shifts in from the right
    always_comb
    begin
        logic [DIFF_W:0] t;
        logic [DIFF_W:0] d;
        logic            ge;
        t  = {in_work.rem, in_work.sh[DIFF_W-1]};
        d  = {1'b0, in_work.md};
        ge = (t >= d);
        work_next     = in_work;
        work_next.rem = ge ? DIFF_W'(t - d) : t[DIFF_W-1:0];
        work_next.sh  = {in_work.sh[DIFF_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

/* hdl/csc_pass.sv */
`timescale 1ns / 1ps
module csc_pass (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  csc_pkg::seg_t in_seg,
    input  csc_pkg::win_t win,
    output logic          out_valid,
    output csc_pkg::seg_t out_seg
);
    import csc_pkg::*;

    typedef struct packed {
        seg_t              seg;
        logic              move;
        logic              mv1;
        logic              y_edge;
        coord_t            a0;
        coord_t            edge_val;
        logic              neg;
        logic [DIFF_W-1:0] ma;
        logic [DIFF_W-1:0] mm;
        logic [DIFF_W-1:0] md;
    } setup_t;

    logic   setup_valid_reg;
    setup_t setup_reg;
    setup_t setup_next;
    logic   mul_valid_reg;
    work_t  mul_reg;
    work_t  mul_next;
    logic   fin_valid_reg;
    seg_t   fin_reg;
    seg_t   fin_next;

    logic   div_v [0:DIV_STAGES];
    work_t  div_w [0:DIV_STAGES];

    // decide, pick the outside endpoint and edge, form the differences
    always_comb
    begin
        rcode_t                   co;
        coord_t                   a1;
        coord_t                   b0;
        coord_t                   b1;
        logic signed [DIFF_W-1:0] da;
        logic signed [DIFF_W-1:0] dm;
        logic signed [DIFF_W-1:0] db;
        setup_next      = '0;
        setup_next.seg  = in_seg;
        if (!in_seg.ok && !in_seg.rej)
        begin
            if ((in_seg.c0 | in_seg.c1) == 4'b0000)
                setup_next.seg.ok = 1'b1;
            else if ((in_seg.c0 & in_seg.c1) != 4'b0000)
                setup_next.seg.rej = 1'b1;
            else
                setup_next.move = 1'b1;
        end
        setup_next.mv1    = (in_seg.c1 > in_seg.c0);
        co                = setup_next.mv1 ? in_seg.c1 : in_seg.c0;
        setup_next.y_edge = ((co & (RC_ABOVE | RC_BELOW)) != 4'b0000);
        if ((co & RC_ABOVE) != 4'b0000)
            setup_next.edge_val = win.high_y;
        else if ((co & RC_BELOW) != 4'b0000)
            setup_next.edge_val = win.low_y;
        else if ((co & RC_RIGHT) != 4'b0000)
            setup_next.edge_val = win.right;
        else
            setup_next.edge_val = win.left;
        if (setup_next.y_edge)
        begin
            setup_next.a0 = in_seg.x0;
            a1            = in_seg.x1;
            b0            = in_seg.y0;
            b1            = in_seg.y1;
        end
        else
        begin
            setup_next.a0 = in_seg.y0;
            a1            = in_seg.y1;
            b0            = in_seg.x0;
            b1            = in_seg.x1;
        end
        da = $signed({a1[COORD_W-1], a1}) - $signed({setup_next.a0[COORD_W-1], setup_next.a0});
        dm = $signed({setup_next.edge_val[COORD_W-1], setup_next.edge_val})
             - $signed({b0[COORD_W-1], b0});
        db = $signed({b1[COORD_W-1], b1}) - $signed({b0[COORD_W-1], b0});
        setup_next.neg = da[DIFF_W-1] ^ dm[DIFF_W-1] ^ db[DIFF_W-1];
        setup_next.ma  = da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da);
        setup_next.mm  = dm[DIFF_W-1] ? DIFF_W'(-dm) : DIFF_W'(dm);
        setup_next.md  = db[DIFF_W-1] ? DIFF_W'(-db) : DIFF_W'(db);
    end

    // full-width product, upper part seeds the remainder
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        prod              = PROD_W'(setup_reg.ma) * PROD_W'(setup_reg.mm);
        mul_next.seg      = setup_reg.seg;
        mul_next.move     = setup_reg.move;
        mul_next.mv1      = setup_reg.mv1;
        mul_next.y_edge   = setup_reg.y_edge;
        mul_next.a0       = setup_reg.a0;
        mul_next.edge_val = setup_reg.edge_val;
        mul_next.neg      = setup_reg.neg;
        mul_next.md       = setup_reg.md;
        mul_next.rem      = prod[PROD_W-1:DIFF_W];
        mul_next.sh       = prod[DIFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
            mul_valid_reg   <= 1'b0;
            fin_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            setup_valid_reg <= in_valid;
            mul_valid_reg   <= setup_valid_reg;
            fin_valid_reg   <= div_v[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setup_reg <= setup_next;
            mul_reg   <= mul_next;
            fin_reg   <= fin_next;
        end
    end

    // divider chain, one quotient bit per stage
    assign div_v[0] = mul_valid_reg;
    assign div_w[0] = mul_reg;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        csc_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_v[i]),
            .in_work   (div_w[i]),
            .out_valid (div_v[i+1]),
            .out_work  (div_w[i+1])
        );
    end

    // apply sign, add to base, move the chosen endpoint onto the edge
    always_comb
    begin
        work_t             w;
        logic [DIFF_W-1:0] qs;
        coord_t            sum;
        coord_t            nx;
        coord_t            ny;
        w   = div_w[DIV_STAGES];
        qs  = w.neg ? (~w.sh + DIFF_W'(1)) : w.sh;
        sum = w.a0 + qs[COORD_W-1:0];
        if (w.y_edge)
        begin
            nx = sum;
            ny = w.edge_val;
        end
        else
        begin
            nx = w.edge_val;
            ny = sum;
        end
        fin_next = w.seg;
        if (w.move)
        begin
            if (w.mv1)
            begin
                fin_next.x1 = nx;
                fin_next.y1 = ny;
            end
            else
            begin
                fin_next.x0 = nx;
                fin_next.y0 = ny;
            end
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_seg   = fin_reg;

endmodule
